[rtl/owbm_pkg.sv]
// Shared types and constants for the one-wire bus master.
// Used by owbm_cfg, owbm_core and one_wire_bus_master; no dependencies.
package owbm_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_RESET_LOW    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESENCE_END = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESET_PERIOD = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SLOT         = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ONE_LOW      = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ZERO_LOW     = 3'd5;

  localparam int unsigned CfgDataW = 12;

  // Reset values of the timing registers
  localparam logic [11:0] RESET_LOW_RST    = 12'd500;
  localparam logic [11:0] PRESENCE_END_RST = 12'd750;
  localparam logic [11:0] RESET_PERIOD_RST = 12'd1001;
  localparam logic [7:0]  SLOT_RST         = 8'd71;
  localparam logic [7:0]  ONE_LOW_RST      = 8'd3;
  localparam logic [7:0]  ZERO_LOW_RST     = 8'd65;

  // Command codes of the mode field; the remaining code acts as a plain tick
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_RESET = 2'd1;
  localparam logic [1:0] MODE_BYTE  = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RESET = 2'd1,
    PH_BYTE  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [11:0] reset_low;
    logic [11:0] presence_end;
    logic [11:0] reset_period;
    logic [7:0]  slot;
    logic [7:0]  one_low;
    logic [7:0]  zero_low;
  } owbm_cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_byte;
    logic       rejected;
  } owbm_res_t;

endpackage

[rtl/one_wire_bus_master.sv]
// Top level of the one-wire bus master: timing registers, sequencer, result register.
// Depends on owbm_pkg, owbm_cfg and owbm_core.
//
// One-wire bus master driven by one input beat per bus tick (typically one
// microsecond). Each accepted beat carries a command (plain tick, bus reset or
// byte transfer), the byte to send and the sampled line level; it yields exactly
// one result beat with the open-drain drive, busy, done, presence, the received
// byte and a rejected flag for a start that arrived while a command was running.
// The sequencer state advances at the accepting edge and the result lands in
// the output register, so a new beat is taken every cycle while the result
// register is empty or being taken. in_stall_o rises only when a result is held
// and the far side stalls. Timing registers are written through the cfg port
// (index 0 reset low, 1 presence end, 2 reset period, 3 slot, 4 one low, 5 zero
// low); the user must write them only while no command is running, which the
// block itself does not enforce. They reset to standard one-wire timings in ticks.
module one_wire_bus_master import owbm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          mode_i,
  input  logic [7:0]          tx_byte_i,
  input  logic                line_level_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                drive_low_o,
  output logic                busy_res_o,
  output logic                done_res_o,
  output logic                presence_o,
  output logic [7:0]          rx_byte_o,
  output logic                rejected_o
);

  owbm_cfg_t cfg;
  owbm_res_t res;
  owbm_res_t res_q;
  logic      out_valid_q, out_valid_d;
  logic      accept;

  // Hold the input only while a result waits and the far side stalls
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  owbm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // Advance the bus sequencer by one tick per accepted beat
  owbm_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .mode_i       (mode_i),
    .tx_byte_i    (tx_byte_i),
    .line_level_i (line_level_i),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_low_o = res_q.drive_low;
  assign busy_res_o  = res_q.busy_res;
  assign done_res_o  = res_q.done_res;
  assign presence_o  = res_q.presence;
  assign rx_byte_o   = res_q.rx_byte;
  assign rejected_o  = res_q.rejected;

endmodule

[rtl/owbm_cfg.sv]
// Timing register file of the one-wire bus master.
// Depends on owbm_pkg for register indexes, reset values and owbm_cfg_t.
module owbm_cfg import owbm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [CfgIdxW-1:0]  idx_i,
  input  logic [CfgDataW-1:0] wdata_i,
  output owbm_cfg_t           cfg_o
);

  owbm_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        CFG_RESET_LOW:    cfg_d.reset_low    = wdata_i;
        CFG_PRESENCE_END: cfg_d.presence_end = wdata_i;
        CFG_RESET_PERIOD: cfg_d.reset_period = wdata_i;
        CFG_SLOT:         cfg_d.slot         = wdata_i[7:0];
        CFG_ONE_LOW:      cfg_d.one_low      = wdata_i[7:0];
        CFG_ZERO_LOW:     cfg_d.zero_low     = wdata_i[7:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low    <= RESET_LOW_RST;
      cfg_q.presence_end <= PRESENCE_END_RST;
      cfg_q.reset_period <= RESET_PERIOD_RST;
      cfg_q.slot         <= SLOT_RST;
      cfg_q.one_low      <= ONE_LOW_RST;
      cfg_q.zero_low     <= ZERO_LOW_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/owbm_core.sv]
// Bus sequencer of the one-wire bus master: phase, tick and bit counters, shifters.
// Depends on owbm_pkg for phase_e, mode codes, owbm_cfg_t and owbm_res_t.
module owbm_core import owbm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [1:0] mode_i,
  input  logic [7:0] tx_byte_i,
  input  logic       line_level_i,
  input  owbm_cfg_t  cfg_i,
  output owbm_res_t  res_o
);

  phase_e      phase_q, phase_d;
  logic [11:0] tick_q, tick_d;
  logic [2:0]  bit_q, bit_d;
  logic [7:0]  tx_q, tx_d;
  logic [7:0]  rx_q, rx_d;
  logic        pres_q, pres_d;

  // Effective state after a start command is taken
  phase_e      ph;
  logic [11:0] t;
  logic [2:0]  bi;
  logic [11:0] period;
  logic [12:0] t_inc;
  logic [7:0]  slot;
  logic [7:0]  slot_m1;
  logic [7:0]  low_raw;
  logic [7:0]  low;
  logic        tx_bit;

  assign period  = (cfg_i.reset_period == '0) ? 12'd1 : cfg_i.reset_period;
  assign slot    = (cfg_i.slot == '0) ? 8'd1 : cfg_i.slot;
  assign slot_m1 = slot - 8'd1;

  always_comb begin
    ph     = phase_q;
    t      = tick_q;
    bi     = bit_q;
    tx_d   = tx_q;
    rx_d   = rx_q;
    pres_d = pres_q;
    res_o  = '0;

    // Take a start command only when idle
    if (mode_i == MODE_RESET || mode_i == MODE_BYTE) begin
      if (phase_q != PH_IDLE) begin
        res_o.rejected = 1'b1;
      end else begin
        t  = '0;
        bi = '0;
        if (mode_i == MODE_RESET) begin
          ph     = PH_RESET;
          pres_d = 1'b0;
        end else begin
          ph   = PH_BYTE;
          tx_d = tx_byte_i;
          rx_d = '0;
        end
      end
    end

    phase_d = ph;
    tick_d  = t;
    bit_d   = bi;
    t_inc   = {1'b0, t} + 13'd1;

    // Low time of the bit in this slot, clipped to leave a sample tick
    tx_bit  = tx_d[bi];
    low_raw = tx_bit ? cfg_i.one_low : cfg_i.zero_low;
    low     = (low_raw > slot_m1) ? slot_m1 : low_raw;

    case (ph)
      PH_RESET: begin
        res_o.busy_res  = 1'b1;
        res_o.drive_low = (t < cfg_i.reset_low);
        if (t >= cfg_i.reset_low && t < cfg_i.presence_end && !line_level_i) begin
          pres_d = 1'b1;
        end
        if (t_inc >= {1'b0, period}) begin
          res_o.done_res = 1'b1;
          phase_d        = PH_IDLE;
          tick_d         = '0;
        end else begin
          tick_d = t_inc[11:0];
        end
      end
      PH_BYTE: begin
        res_o.busy_res  = 1'b1;
        res_o.drive_low = (t < {4'b0, low});
        if (t == {4'b0, low} && line_level_i) begin
          rx_d[bi] = 1'b1;
        end
        if (t_inc >= {5'b0, slot}) begin
          tick_d = '0;
          if (bi == 3'd7) begin
            res_o.done_res = 1'b1;
            phase_d        = PH_IDLE;
            bit_d          = '0;
          end else begin
            bit_d = bi + 3'd1;
          end
        end else begin
          tick_d = t_inc[11:0];
        end
      end
      default: begin
        phase_d = ph;
      end
    endcase

    res_o.presence = pres_d;
    res_o.rx_byte  = rx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      tx_q    <= '0;
      rx_q    <= '0;
      pres_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      tx_q    <= tx_d;
      rx_q    <= rx_d;
      pres_q  <= pres_d;
    end
  end

`ifndef SYNTH
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.done_res |=> phase_q == PH_IDLE)
    else $error("command finished but phase not idle");

  a_reject_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.rejected |-> phase_q != PH_IDLE)
    else $error("start rejected while idle");

  a_idle_counters_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> tick_q == '0 && bit_q == '0)
    else $error("counters not cleared in idle");

  a_done_is_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_IDLE && res_o.done_res |-> res_o.busy_res)
    else $error("done without an active command");
`endif

endmodule

[sim/tb_one_wire_bus_master.sv]
`timescale 1ns / 1ps
// Self-checking testbench for one_wire_bus_master: drives bus ticks, predicts every result beat.
// Depends on owbm_pkg and one_wire_bus_master from the rtl folder.
module tb_one_wire_bus_master;
  import owbm_pkg::*;

  // Mode code with no command behind it and the two register slots with no register behind them
  localparam logic [1:0]         MODE_SPARE   = 2'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

  localparam int StuckLimit  = 2000;  // cycles with no beat on either side before giving up
  localparam int ShownErrors = 10;
  localparam int RandomTicks = 100;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i    = CFG_RESET_LOW;
  logic [CfgDataW-1:0] cfg_wdata_i  = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [1:0]          mode_i       = MODE_TICK;
  logic [7:0]          tx_byte_i    = '0;
  logic                line_level_i = 1'b1;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic                drive_low_o;
  logic                busy_res_o;
  logic                done_res_o;
  logic                presence_o;
  logic [7:0]          rx_byte_o;
  logic                rejected_o;

  one_wire_bus_master u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .mode_i, .tx_byte_i, .line_level_i,
    .out_valid_o, .out_stall_i, .drive_low_o, .busy_res_o, .done_res_o,
    .presence_o, .rx_byte_o, .rejected_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predicted bus master: own copy of timing registers and sequencer state.
  // ---------------------------------------------------------------------------
  owbm_cfg_t   timing = '{RESET_LOW_RST, PRESENCE_END_RST, RESET_PERIOD_RST,
                          SLOT_RST, ONE_LOW_RST, ZERO_LOW_RST};
  phase_e      bus_phase     = PH_IDLE;
  logic [11:0] slot_tick     = '0;
  logic [2:0]  bit_pos       = '0;
  logic [7:0]  tx_bits       = '0;
  logic [7:0]  rx_bits       = '0;
  logic        presence_flag = 1'b0;

  owbm_res_t expected_beats[$];

  int  ticks_sent    = 0;
  int  beats_checked = 0;
  int  mismatch_cnt  = 0;
  int  done_cnt      = 0;
  int  rejected_cnt  = 0;
  int  stuck_cycles  = 0;
  bit  sender_idles  = 1'b1;
  bit  receiver_idles = 1'b1;

  // Advance the predicted sequencer by one bus tick and return the result beat it yields.
  function automatic owbm_res_t step_bus(input logic [1:0] mode, input logic [7:0] tx,
                                         input logic line);
    owbm_res_t   r;
    int unsigned t;
    int unsigned span;
    int unsigned low;
    r = '0;
    // A start is taken only when no command runs; otherwise flag it and carry on.
    if (mode == MODE_RESET || mode == MODE_BYTE) begin
      if (bus_phase != PH_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        slot_tick = '0;
        bit_pos   = '0;
        if (mode == MODE_RESET) begin
          bus_phase     = PH_RESET;
          presence_flag = 1'b0;
        end else begin
          bus_phase = PH_BYTE;
          tx_bits   = tx;
          rx_bits   = '0;
        end
      end
    end
    case (bus_phase)
      PH_RESET: begin
        t    = slot_tick;
        span = (timing.reset_period == 0) ? 1 : timing.reset_period;
        r.busy_res  = 1'b1;
        r.drive_low = (t < timing.reset_low);
        // Presence window opens when the pulse is released, closes at presence_end.
        if (t >= timing.reset_low && t < timing.presence_end && !line) presence_flag = 1'b1;
        if (t + 1 >= span) begin
          r.done_res = 1'b1;
          bus_phase  = PH_IDLE;
          slot_tick  = '0;
        end else begin
          slot_tick = 12'(t + 1);
        end
      end
      PH_BYTE: begin
        t    = slot_tick;
        span = (timing.slot == 0) ? 1 : timing.slot;
        low  = tx_bits[bit_pos] ? timing.one_low : timing.zero_low;
        // Clip the low time so every slot still has its sample point.
        if (low > span - 1) low = span - 1;
        r.busy_res  = 1'b1;
        r.drive_low = (t < low);
        if (t == low && line) rx_bits[bit_pos] = 1'b1;
        if (t + 1 >= span) begin
          slot_tick = '0;
          if (bit_pos == 3'd7) begin
            r.done_res = 1'b1;
            bus_phase  = PH_IDLE;
            bit_pos    = '0;
          end else begin
            bit_pos = bit_pos + 3'd1;
          end
        end else begin
          slot_tick = 12'(t + 1);
        end
      end
      default: ;
    endcase
    r.presence = presence_flag;
    r.rx_byte  = rx_bits;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Edge monitor: check the result beat leaving, then predict for the tick entering.
  // The result taken at this edge always belongs to an earlier tick, so check first.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    owbm_res_t got;
    owbm_res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{drive_low_o, busy_res_o, done_res_o, presence_o, rx_byte_o, rejected_o};
        if (expected_beats.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= ShownErrors)
            $display("beat %0d: result with nothing expected (actual %p)", beats_checked, got);
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= ShownErrors)
              $display({"beat %0d exp/act: drive %b/%b busy %b/%b done %b/%b ",
                        "presence %b/%b rx %h/%h rejected %b/%b"}, beats_checked,
                       want.drive_low, got.drive_low, want.busy_res, got.busy_res,
                       want.done_res, got.done_res, want.presence, got.presence,
                       want.rx_byte, got.rx_byte, want.rejected, got.rejected);
          end
        end
        beats_checked++;
      end
      // Register writes only happen with the input side quiet, so order does not matter.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RESET_LOW:    timing.reset_low    = cfg_wdata_i;
          CFG_PRESENCE_END: timing.presence_end = cfg_wdata_i;
          CFG_RESET_PERIOD: timing.reset_period = cfg_wdata_i;
          CFG_SLOT:         timing.slot         = cfg_wdata_i[7:0];
          CFG_ONE_LOW:      timing.one_low      = cfg_wdata_i[7:0];
          CFG_ZERO_LOW:     timing.zero_low     = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        want = step_bus(mode_i, tx_byte_i, line_level_i);
        expected_beats.push_back(want);
        if (want.done_res) done_cnt++;
        if (want.rejected) rejected_cnt++;
      end
    end
  end

  // Watchdog: a run that stops moving beats is a hang.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == StuckLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver back-pressure: random stalls unless a quiet stretch is running.
  always @(negedge clk_i) begin
    out_stall_i <= receiver_idles && ($urandom_range(99) < 11);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All of them start and end on a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one tick beat, hold it until taken, return on the next falling edge.
  task automatic send_tick(input logic [1:0] mode, input logic [7:0] tx, input logic line);
    if (sender_idles) begin
      while ($urandom_range(99) < 11) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    tx_byte_i    <= tx;
    line_level_i <= line;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    ticks_sent++;
  endtask

  // Start a command and feed ticks until the predicted sequencer is idle again.
  // The line is high at pct_high percent, or low only on tick low_at when that is set.
  // noise_pct replaces that share of the following ticks with stray starts or the spare mode.
  task automatic run_command(input logic [1:0] mode, input logic [7:0] tx, input int pct_high,
                             input int low_at, input int noise_pct);
    int         k;
    logic [1:0] m;
    logic       line;
    k = 0;
    do begin
      m = (k == 0) ? mode : MODE_TICK;
      if (k != 0 && $urandom_range(99) < noise_pct) begin
        case ($urandom_range(2))
          0:       m = MODE_RESET;
          1:       m = MODE_BYTE;
          default: m = MODE_SPARE;
        endcase
      end
      if (low_at >= 0) line = (k != low_at);
      else line = ($urandom_range(99) < pct_high);
      send_tick(m, (k == 0) ? tx : 8'($urandom()), line);
      k++;
    end while (bus_phase != PH_IDLE);
  endtask

  // Ticks that start nothing: plain or spare mode with random payload.
  task automatic idle_ticks(input int n);
    repeat (n) send_tick($urandom_range(1) ? MODE_TICK : MODE_SPARE, 8'($urandom()),
                         1'($urandom()));
  endtask

  // Drop valid and wait until every predicted beat has come back, plus a short margin.
  task automatic settle_bus();
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Write all six timing registers back to back; spare upper bits of 8-bit ones are random.
  task automatic load_timing(input owbm_cfg_t c);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_RESET_LOW;
    cfg_wdata_i <= c.reset_low;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_PRESENCE_END;
    cfg_wdata_i <= c.presence_end;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_RESET_PERIOD;
    cfg_wdata_i <= c.reset_period;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_SLOT;
    cfg_wdata_i <= {4'($urandom()), c.slot};
    @(negedge clk_i);
    cfg_idx_i   <= CFG_ONE_LOW;
    cfg_wdata_i <= {4'($urandom()), c.one_low};
    @(negedge clk_i);
    cfg_idx_i   <= CFG_ZERO_LOW;
    cfg_wdata_i <= {4'($urandom()), c.zero_low};
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Standard timings straight out of reset: one byte with a mixed bit pattern.
  task automatic test_default_timing();
    run_command(MODE_BYTE, 8'ha5, 50, -1, 0);
    settle_bus();
  endtask

  // Zero, one, maximum and clipped timings; writes to the unused register slots.
  task automatic test_timing_extremes();
    owbm_cfg_t c;
    c = '0;
    load_timing(c);
    run_command(MODE_RESET, 8'h00, 0, -1, 0);
    run_command(MODE_BYTE, 8'h96, 100, -1, 0);
    settle_bus();
    c = '{reset_low: 12'd1, presence_end: 12'd1, reset_period: 12'd1,
          slot: 8'd1, one_low: 8'd1, zero_low: 8'd1};
    load_timing(c);
    run_command(MODE_RESET, 8'hff, 0, -1, 0);
    run_command(MODE_BYTE, 8'h69, 50, -1, 0);
    settle_bus();
    // Low times past the slot end get clipped to the last tick of the slot.
    c = '{reset_low: 12'd2, presence_end: 12'd4, reset_period: 12'd6,
          slot: 8'd5, one_low: 8'd200, zero_low: 8'd9};
    load_timing(c);
    run_command(MODE_BYTE, 8'h0f, 50, -1, 0);
    run_command(MODE_BYTE, 8'hff, 100, -1, 0);
    settle_bus();
    // Unused slots must leave every timing alone.
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SPARE_LO;
    cfg_wdata_i <= 12'($urandom());
    @(negedge clk_i);
    cfg_idx_i   <= CFG_SPARE_HI;
    cfg_wdata_i <= 12'($urandom());
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    run_command(MODE_BYTE, 8'hf0, 50, -1, 0);
    settle_bus();
    // Full-scale pulse, window and low times, cut short by a brief period and slot.
    c = '{reset_low: 12'hfff, presence_end: 12'hfff, reset_period: 12'd24,
          slot: 8'd16, one_low: 8'hff, zero_low: 8'hff};
    load_timing(c);
    run_command(MODE_RESET, 8'h00, 50, -1, 0);
    run_command(MODE_BYTE, 8'h81, 50, -1, 0);
    settle_bus();
  endtask

  // Presence window edges, a silent bus, and resets shorter than pulse or window.
  task automatic test_presence_window();
    owbm_cfg_t c;
    c = '{reset_low: 12'd5, presence_end: 12'd9, reset_period: 12'd12,
          slot: 8'd6, one_low: 8'd1, zero_low: 8'd4};
    load_timing(c);
    run_command(MODE_RESET, 8'h00, 100, 4, 0);   // low while still driving: no presence
    run_command(MODE_RESET, 8'h00, 100, 5, 0);   // first tick of the window
    run_command(MODE_RESET, 8'h00, 100, 8, 0);   // last tick of the window
    run_command(MODE_RESET, 8'h00, 100, 9, 0);   // just past the window
    run_command(MODE_RESET, 8'h00, 100, -1, 0);  // no slave answers
    settle_bus();
    // Pulse longer than the whole reset: line never released, window never opens.
    c = '{reset_low: 12'd10, presence_end: 12'd20, reset_period: 12'd7,
          slot: 8'd6, one_low: 8'd1, zero_low: 8'd4};
    load_timing(c);
    run_command(MODE_RESET, 8'h00, 0, -1, 0);
    settle_bus();
    // Window running past the end of the reset is cut at the last tick.
    c = '{reset_low: 12'd3, presence_end: 12'd30, reset_period: 12'd8,
          slot: 8'd6, one_low: 8'd1, zero_low: 8'd4};
    load_timing(c);
    run_command(MODE_RESET, 8'h00, 100, 7, 0);
    settle_bus();
  endtask

  // Starts landing on a running command, back-to-back commands, spare mode while idle.
  task automatic test_busy_start();
    owbm_cfg_t c;
    c = '{reset_low: 12'd4, presence_end: 12'd8, reset_period: 12'd10,
          slot: 8'd7, one_low: 8'd2, zero_low: 8'd5};
    load_timing(c);
    idle_ticks(4);
    run_command(MODE_BYTE, 8'h3c, 50, -1, 40);
    run_command(MODE_RESET, 8'hc3, 50, -1, 40);
    run_command(MODE_BYTE, 8'hff, 50, -1, 40);
    idle_ticks(3);
    settle_bus();
  endtask

  // Random timing sets, each with a run of well-formed commands on a noisy bus.
  task automatic test_random_traffic();
    owbm_cfg_t c;
    int        start;
    int        round;
    int        pct;
    start = ticks_sent;
    round = 0;
    while (round < 2 || ticks_sent - start < RandomTicks) begin
      // Keep one set free of idles on both sides so the block runs at full rate.
      sender_idles   = (round != 1);
      receiver_idles <= (round != 1);
      c.reset_low    = 12'($urandom_range(20));
      c.presence_end = 12'($urandom_range(30));
      c.reset_period = 12'($urandom_range(40));
      c.slot         = 8'($urandom_range(12));
      c.one_low      = 8'($urandom_range(14));
      c.zero_low     = 8'($urandom_range(14));
      load_timing(c);
      repeat ($urandom_range(3, 6)) begin
        case ($urandom_range(3))
          0:       pct = 0;
          1:       pct = 50;
          2:       pct = 90;
          default: pct = 100;
        endcase
        if ($urandom_range(1)) run_command(MODE_RESET, 8'($urandom()), pct, -1, 5);
        else run_command(MODE_BYTE, ($urandom_range(3) == 0) ? 8'hff : 8'($urandom()),
                         pct, -1, 5);
        idle_ticks($urandom_range(3));
      end
      settle_bus();
      round++;
    end
    sender_idles   = 1'b1;
    receiver_idles <= 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset once, run the tests in turn, drain, report.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_default_timing();
    test_timing_extremes();
    test_presence_window();
    test_busy_start();
    test_random_traffic();
    settle_bus();
    $display("Sent %0d bus ticks, checked %0d result beats; %0d commands completed.",
             ticks_sent, beats_checked, done_cnt);
    $display("Timings ran from zero to full scale with clipped low times; %0d starts rejected.",
             rejected_cnt);
    if (mismatch_cnt == 0 && expected_beats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
